// ----- rtl/ecsc_pkg.sv -----
// Shared types, constants and tables for the envelope compressor with soft clipper.
package ecsc_pkg;

    localparam int IN_WIDTH = 24;
    localparam int MAG_W = 23;
    localparam int COEF_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;

    localparam logic [COEF_W-1:0] ATTACK_RESET = 24'd16748107;
    localparam logic [COEF_W-1:0] RELEASE_RESET = 24'd16775760;

    localparam logic [MAG_W-1:0] ENV_MAX = 23'd8388607;
    localparam logic [MAG_W-1:0] THRESH_Q20 = 23'd167772;
    // Log2 of the threshold in Q.16, from the same interpolated table.
    localparam logic [20:0] LG_THRESH = 21'd1137424;
    // Reciprocal of three in Q.21, exact for operands below 2^21.
    localparam logic [19:0] RECIP3_Q21 = 20'd699051;
    localparam logic [15:0] DRIVE_Q14 = 16'd39322;
    localparam logic [15:0] CLAMP_Q15 = 16'd30146;
    localparam logic [16:0] UNITY_Q16 = 17'd65536;

    localparam logic [16:0] LOG2_TAB [17] = '{
        17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
        17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
        17'd56229, 17'd59434, 17'd62534, 17'd65536
    };

    localparam logic [16:0] EXP2N_TAB [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    localparam logic [14:0] TANH_TAB [17] = '{
        15'd0, 15'd6260, 15'd11811, 15'd16234, 15'd19466, 15'd21681, 15'd23135,
        15'd24061, 15'd24640, 15'd24997, 15'd25217, 15'd25350, 15'd25433,
        15'd25482, 15'd25512, 15'd25531, 15'd25542
    };

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_LG,
        ST_DIV,
        ST_EXP,
        ST_GAIN,
        ST_DRIVE,
        ST_CLIP
    } t_step;

endpackage

// ----- rtl/envelope_compressor_soft_clip_unit.sv -----
// Top level of the envelope compressor with tanh soft clipper.
// Usage:
// The input channel (i_valid, o_stall, i_sample_in) takes one signed Q3.20 sample per
// transfer. The output channel (o_valid, i_stall, o_sample_out) returns one Q1.15
// sample per input, in order. Attack and release coefficients are written through
// i_cfg_we, i_cfg_idx and i_cfg_data while the block is idle; other indexes are ignored.
// An input stage registers the sign and magnitude of the sample, a two-entry queue
// follows, and an eight-step sequencer computes the envelope, the gain, the drive and
// the clip. The sequencer works on one sample at a time and takes the next one from
// the queue only after the last has left its final step, so that each envelope update
// sees the previous one.
// Reset clears the envelope to zero, loads the 48 kHz coefficient defaults and
// empties the queue and the output register.
// When the receiver stalls, the result stays in the output register, the sequencer
// waits at its last step and the queue and input stage fill before o_stall rises.
module envelope_compressor_soft_clip_unit
    import ecsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [IN_WIDTH-1:0]  i_sample_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_W-1:0]     o_sample_out
);

    logic  push;
    logic  full;
    logic  q_valid;
    logic  pop;
    t_item front_item;
    t_item q_item;

    ecsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_in (i_sample_in),
        .o_push      (push),
        .o_item      (front_item),
        .i_full      (full)
    );

    ecsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    ecsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out)
    );

endmodule

// ----- rtl/ecsc_front.sv -----
// Input stage: takes samples and turns them into a saturated magnitude and a sign.
module ecsc_front
    import ecsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [IN_WIDTH-1:0] i_sample_in,
    output logic                o_push,
    output t_item               o_item,
    input  logic                i_full
);

    logic                       r_vld;
    t_item                      r_item;
    t_item                      n_item;
    logic [IN_WIDTH-1:0]        neg_raw;
    logic [IN_WIDTH+COEF_W-1:0] scaled;
    logic [COEF_W-1:0]          mag24;

    assign o_stall = r_vld && i_full;
    assign o_push = r_vld && !i_full;
    assign o_item = r_item;

    always_comb begin
        neg_raw = i_sample_in[IN_WIDTH-1] ? (IN_WIDTH'(0) - i_sample_in) : i_sample_in;
        // Kept in Q3.20: the magnitude goes over 24 fraction bits and is shifted back.
        scaled = {neg_raw, {COEF_W{1'b0}}} >> IN_WIDTH;
        mag24 = scaled[COEF_W-1:0];
        n_item.neg = i_sample_in[IN_WIDTH-1];
        n_item.mag = mag24[COEF_W-1] ? ENV_MAX : mag24[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/ecsc_queue.sv -----
// Two-entry queue between the input stage and the processing sequencer.
module ecsc_queue
    import ecsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;

    assign o_full = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ----- rtl/ecsc_back.sv -----
// Processing sequencer: envelope update, gain computation, soft clip and output register.
module ecsc_back
    import ecsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_W-1:0]     o_sample_out
);

    t_step             r_step;
    t_step             n_step;
    logic [COEF_W-1:0] r_attack;
    logic [COEF_W-1:0] r_release;
    logic [MAG_W-1:0]  r_env;
    logic              r_ovld;
    logic [OUT_W-1:0]  r_out;

    logic [MAG_W-1:0]  r_m;
    logic              r_neg;
    logic [COEF_W-1:0] r_c;
    logic [MAG_W-1:0]  r_d;
    logic              r_up;
    logic [20:0]       r_lg;
    logic              r_gt;
    logic [21:0]       r_y;
    logic [16:0]       r_g;
    logic [MAG_W-1:0]  r_gained;
    logic [24:0]       r_x;

    logic              load_out;
    logic              out_free;

    logic [COEF_W-1:0] n_c;
    logic [MAG_W-1:0]  n_d;
    logic [47:0]       env_prod;
    logic [MAG_W-1:0]  env_q;
    logic [MAG_W-1:0]  n_env;
    logic [4:0]        lead;
    logic [38:0]       norm;
    logic [15:0]       lg_f;
    logic [4:0]        lg_seg;
    logic [16:0]       lg_diff;
    logic [28:0]       lg_prod;
    logic [20:0]       n_lg;
    logic [20:0]       lg_l;
    logic [23:0]       div_t;
    logic [42:0]       div_prod;
    logic [5:0]        exp_n;
    logic [4:0]        exp_seg;
    logic [16:0]       exp_diff;
    logic [28:0]       exp_prod;
    logic [16:0]       exp_v;
    logic [16:0]       n_g;
    logic [39:0]       gain_prod;
    logic [39:0]       drive_sum;
    logic [4:0]        tanh_seg;
    logic [14:0]       tanh_diff;
    logic [32:0]       tanh_prod;
    logic [15:0]       clip_v;
    logic [15:0]       n_out;

    assign o_valid = r_ovld;
    assign o_sample_out = r_out;
    assign out_free = !r_ovld || !i_stall;

    always_comb begin
        n_step = r_step;
        o_pop = 1'b0;
        load_out = 1'b0;
        unique case (r_step)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_step = ST_ENV;
                end
            end
            ST_ENV:   n_step = ST_LG;
            ST_LG:    n_step = ST_DIV;
            ST_DIV:   n_step = ST_EXP;
            ST_EXP:   n_step = ST_GAIN;
            ST_GAIN:  n_step = ST_DRIVE;
            ST_DRIVE: n_step = ST_CLIP;
            ST_CLIP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_step = ST_IDLE;
                end
            end
            default:  n_step = ST_IDLE;
        endcase
    end

    always_comb begin
        // Envelope smoother; rounding is applied to the part kept from the old envelope.
        n_c = (i_q_item.mag > r_env) ? r_attack : r_release;
        n_d = (r_env >= i_q_item.mag) ? (r_env - i_q_item.mag) : (i_q_item.mag - r_env);
        env_prod = r_c * r_d + 48'd8388608;
        env_q = env_prod[46:24];
        n_env = r_up ? (r_m + env_q) : (r_m - env_q);

        // Log2 of the envelope: leading one, normalized mantissa, interpolation.
        lead = 5'd0;
        for (int i = 0; i < MAG_W; i++) begin
            if (r_env[i]) begin
                lead = 5'(i);
            end
        end
        norm = {r_env, 16'd0} >> lead;
        lg_f = norm[15:0];
        lg_seg = {1'b0, lg_f[15:12]};
        lg_diff = LOG2_TAB[lg_seg + 5'd1] - LOG2_TAB[lg_seg];
        lg_prod = lg_diff[12:0] * lg_f[11:0];
        n_lg = {lead, 16'd0} + 21'(LOG2_TAB[lg_seg]) + 21'(lg_prod[28:12]);

        // Divide 5L+3 by six as a halving followed by a reciprocal of three.
        lg_l = r_lg - LG_THRESH;
        div_t = 24'(lg_l) * 24'd5 + 24'd3;
        div_prod = div_t[23:1] * RECIP3_Q21;

        exp_n = r_y[21:16];
        exp_seg = {1'b0, r_y[15:12]};
        exp_diff = EXP2N_TAB[exp_seg] - EXP2N_TAB[exp_seg + 5'd1];
        exp_prod = exp_diff[11:0] * r_y[11:0];
        exp_v = EXP2N_TAB[exp_seg] - 17'(exp_prod[28:12]);
        if (!r_gt) begin
            n_g = UNITY_Q16;
        end else if (exp_n > 6'd16) begin
            n_g = 17'd0;
        end else begin
            n_g = exp_v >> exp_n;
        end

        gain_prod = r_m * r_g;
        drive_sum = r_gained * DRIVE_Q14 + 40'd8192;

        // Soft clip table over [0,4); beyond that it holds at the last entry.
        tanh_seg = {1'b0, r_x[21:18]};
        tanh_diff = TANH_TAB[tanh_seg + 5'd1] - TANH_TAB[tanh_seg];
        tanh_prod = tanh_diff * r_x[17:0];
        if (r_x[24:22] != 3'd0) begin
            clip_v = 16'(TANH_TAB[16]);
        end else begin
            clip_v = 16'(TANH_TAB[tanh_seg]) + 16'(tanh_prod[32:18]);
        end
        if (clip_v > CLAMP_Q15) begin
            clip_v = CLAMP_Q15;
        end
        n_out = r_neg ? (16'd0 - clip_v) : clip_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack <= ATTACK_RESET;
            r_release <= RELEASE_RESET;
            r_env <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_ATTACK) begin
                r_attack <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_RELEASE) begin
                r_release <= i_cfg_data;
            end
            if (r_step == ST_ENV) begin
                r_env <= n_env;
            end
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m <= i_q_item.mag;
            r_neg <= i_q_item.neg;
            r_c <= n_c;
            r_d <= n_d;
            r_up <= (r_env >= i_q_item.mag);
        end
        if (r_step == ST_LG) begin
            r_lg <= n_lg;
            r_gt <= (r_env > THRESH_Q20);
        end
        if (r_step == ST_DIV) begin
            r_y <= div_prod[42:21];
        end
        if (r_step == ST_EXP) begin
            r_g <= n_g;
        end
        if (r_step == ST_GAIN) begin
            r_gained <= gain_prod[38:16];
        end
        if (r_step == ST_DRIVE) begin
            r_x <= drive_sum[38:14];
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/ecsc_checker.sv -----
// Port-level checker for the envelope compressor, bound to the top level.
module ecsc_checker
    import ecsc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [OUT_W-1:0]    o_sample_out
);

    // A result waiting on the receiver is held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample_out))
        else $error("output changed while stalled");

    // The soft clip never leaves the clamp range.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_sample_out) <= $signed(CLAMP_Q15)
                  && $signed(o_sample_out) >= -$signed(CLAMP_Q15)))
        else $error("output outside clamp range");

    // Reset empties the output register and the input stage.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("channels not idle after reset");

    // The input side cannot stall unless a sample was taken in the cycle before.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("stall rose without a transfer");

endmodule

bind envelope_compressor_soft_clip_unit ecsc_checker u_ecsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_sample_out (o_sample_out)
);
